// ===== hdl/hrdc_pkg.sv =====
// Shared types and constants for the hysteresis relay with duty cycle.
`default_nettype none
package hrdc_pkg;

  localparam int TempW  = 16;
  localparam int BandW  = 15;
  localparam int TicksW = 16;
  localparam int ErrW   = 18;
  localparam int TimerW = 17;
  localparam int ModeW  = 2;
  localparam int IdxW   = 3;
  localparam int DataW  = 16;

  localparam logic [ModeW-1:0] MODE_TIMED  = 2'd0;
  localparam logic [ModeW-1:0] MODE_FORCED = 2'd1;
  localparam logic [ModeW-1:0] MODE_HOLD   = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [IdxW-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [IdxW-1:0] REG_BIAS      = 3'd1;
  localparam logic [IdxW-1:0] REG_INVERT    = 3'd2;
  localparam logic [IdxW-1:0] REG_BAND      = 3'd3;
  localparam logic [IdxW-1:0] REG_ON_TICKS  = 3'd4;
  localparam logic [IdxW-1:0] REG_OFF_TICKS = 3'd5;

  typedef struct packed {
    logic                    opcode;
    logic signed [TempW-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic             relay_on;
    logic [ModeW-1:0] mode;
  } out_item_t;

  typedef struct packed {
    logic signed [TempW-1:0] setpoint;
    logic signed [TempW-1:0] bias;
    logic                    invert;
    logic [BandW-1:0]        band;
    logic [TicksW-1:0]       on_ticks;
    logic [TicksW-1:0]       off_ticks;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/hysteresis_relay_with_duty_cycle.sv =====
// Top level of the single-channel hysteresis relay with timed duty cycle.
// The block takes one item per clock cycle, sample or tick, and returns one
// result item for each. An accepted item is held in an input register, where
// the error compare, timer wrap and mode decision are done and the channel
// state is updated; its result is registered at the output once the output
// register is free. in_ready drops only while both the input register and
// the output register hold items and out_ready is low. Configuration is
// written through wr_en, wr_index and wr_data and takes effect on the next
// item; configuration and channel state reset to zero, while the item and
// result data registers are not reset.
`default_nettype none
module hysteresis_relay_with_duty_cycle (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [hrdc_pkg::IdxW-1:0]  wr_index,
  input  wire logic [hrdc_pkg::DataW-1:0] wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire hrdc_pkg::in_item_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output hrdc_pkg::out_item_t             out_data
);

  hrdc_pkg::cfg_t      cfg;
  hrdc_pkg::in_item_t  s1_item;
  hrdc_pkg::out_item_t result;
  logic                s1_valid;
  logic                out_free;
  logic                step;

  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  hrdc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  hrdc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_data;
    end
    if (step) begin
      out_data <= result;
    end
  end

  // A forced result always drives the relay on.
  a_forced_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.mode == hrdc_pkg::MODE_FORCED |-> out_data.relay_on)
    else $error("forced mode with relay off");

  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.mode == hrdc_pkg::MODE_TIMED ||
                   out_data.mode == hrdc_pkg::MODE_FORCED ||
                   out_data.mode == hrdc_pkg::MODE_HOLD))
    else $error("result carries an undefined mode");

  // Back pressure only when both stages are full and the output is stalled.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

  // A stalled input stage keeps its item for the next cycle.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_item))
    else $error("input stage lost a stalled item");

endmodule
`default_nettype wire

// ===== hdl/hrdc_cfg.sv =====
// Configuration register file of the relay channel.
`default_nettype none
module hrdc_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [hrdc_pkg::IdxW-1:0]  wr_index,
  input  wire logic [hrdc_pkg::DataW-1:0] wr_data,
  output hrdc_pkg::cfg_t                  cfg
);

  hrdc_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en) begin
      case (wr_index)
        hrdc_pkg::REG_SETPOINT:  regs.setpoint  <= $signed(wr_data);
        hrdc_pkg::REG_BIAS:      regs.bias      <= $signed(wr_data);
        hrdc_pkg::REG_INVERT:    regs.invert    <= wr_data[0];
        hrdc_pkg::REG_BAND:      regs.band      <= wr_data[hrdc_pkg::BandW-1:0];
        hrdc_pkg::REG_ON_TICKS:  regs.on_ticks  <= wr_data;
        hrdc_pkg::REG_OFF_TICKS: regs.off_ticks <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

// ===== hdl/hrdc_core.sv =====
// Relay decision logic and channel state: relay, cycle timer and last mode.
`default_nettype none
module hrdc_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire hrdc_pkg::in_item_t item,
  input  wire hrdc_pkg::cfg_t  cfg,
  output hrdc_pkg::out_item_t result
);

  localparam logic [hrdc_pkg::TimerW-1:0] TimerMax = '1;

  logic                              relay_state, relay_state_next;
  logic [hrdc_pkg::TimerW-1:0]       cycle_timer, cycle_timer_next;
  logic [hrdc_pkg::ModeW-1:0]        last_mode, last_mode_next;

  logic signed [hrdc_pkg::ErrW-1:0]  err_raw, err, band_ext, limit;
  logic [hrdc_pkg::TimerW-1:0]       timer_eff;
  logic [hrdc_pkg::ModeW-1:0]        mode;
  logic                              over_band, timed_on;

  always_comb begin
    // Error is kept at full width so that extreme sums compare by true value.
    err_raw = $signed({{2{cfg.setpoint[hrdc_pkg::TempW-1]}}, cfg.setpoint})
            + $signed({{2{cfg.bias[hrdc_pkg::TempW-1]}}, cfg.bias})
            - $signed({{2{item.temperature[hrdc_pkg::TempW-1]}}, item.temperature});
    err      = cfg.invert ? -err_raw : err_raw;
    band_ext = $signed({3'b000, cfg.band});
    over_band = err > band_ext;

    limit = $signed({2'b00, cfg.on_ticks}) + $signed({2'b00, cfg.off_ticks})
          - 18'sd1;
    timer_eff = ($signed({1'b0, cycle_timer}) > limit) ? '0 : cycle_timer;
    timed_on  = timer_eff < {1'b0, cfg.on_ticks};

    if (cfg.setpoint == '0) begin
      mode = hrdc_pkg::MODE_TIMED;
    end else if (err[hrdc_pkg::ErrW-1]) begin
      mode = hrdc_pkg::MODE_FORCED;
    end else if (over_band) begin
      mode = hrdc_pkg::MODE_TIMED;
    end else begin
      mode = hrdc_pkg::MODE_HOLD;
    end

    if (item.opcode == hrdc_pkg::OP_TICK) begin
      relay_state_next = relay_state;
      last_mode_next   = last_mode;
      cycle_timer_next = (cycle_timer == TimerMax) ? cycle_timer
                                                   : cycle_timer + 1'b1;
    end else begin
      last_mode_next   = mode;
      cycle_timer_next = timer_eff;
      case (mode)
        hrdc_pkg::MODE_TIMED:  relay_state_next = timed_on;
        hrdc_pkg::MODE_FORCED: relay_state_next = 1'b1;
        default:               relay_state_next = relay_state;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state <= 1'b0;
      cycle_timer <= '0;
      last_mode   <= hrdc_pkg::MODE_TIMED;
    end else if (step) begin
      relay_state <= relay_state_next;
      cycle_timer <= cycle_timer_next;
      last_mode   <= last_mode_next;
    end
  end

  assign result.relay_on = relay_state_next;
  assign result.mode     = last_mode_next;

endmodule
`default_nettype wire
